// ===== sv/baro_pkg.sv =====
`timescale 1ns / 1ps
package baro_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned DivCycles = 32;
  localparam int unsigned PaddrW = 5;

  localparam logic [1:0] RegCoefA = 2'd0;
  localparam logic [1:0] RegCoefB = 2'd1;
  localparam logic [1:0] RegCoefC = 2'd2;
  localparam logic [1:0] RegOss = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [18:0] raw_reading;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] result_value;
    logic        divide_fault;
  } out_item_t;

  // Datapath operations issued by the controller, one per step.
  typedef enum logic [4:0] {
    OpIdle,
    OpT0, OpT1, OpT2, OpT3, OpT4,
    OpP0, OpP1, OpP2, OpP3, OpP4, OpP5, OpP6, OpP7, OpP8, OpP9, OpP10,
    OpP11, OpP12, OpP13, OpP14, OpP15
  } op_e;

  typedef struct packed {
    op_e  op;
    logic div_start;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_zero;
  } dp_sts_t;

  typedef struct packed {
    logic [63:0] coef_a;
    logic [63:0] coef_b;
    logic [31:0] coef_c;
    logic [1:0]  oss;
  } coef_t;

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
    asr32 = 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

endpackage

// ===== sv/baro_div.sv =====
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per cycle.
module baro_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output logic [31:0] quo_o
);
  import baro_pkg::*;

  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [32:0] trial;

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    trial = {rem_q, quo_q[31]} - {1'b0, den_q};
    if (start_i) begin
      cnt_d = 6'(DivCycles);
      rem_d = '0;
      quo_d = num_i;
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 6'd1;
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> busy_o)
    else $error("divider did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o && !start_i |=> (cnt_q == $past(cnt_q) - 6'd1))
    else $error("divider count skipped");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o && !start_i |=> !busy_o)
    else $error("divider ran without start");

endmodule

// ===== sv/baro_dp.sv =====
`timescale 1ns / 1ps
module baro_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  baro_pkg::dp_cmd_t cmd_i,
  output baro_pkg::dp_sts_t sts_o,
  input  baro_pkg::coef_t   coef_i,
  input  logic [18:0]       raw_i,
  output logic [31:0]       value_o
);
  import baro_pkg::*;

  logic [31:0] b5_q, b5_d;
  logic [31:0] x1_q, x1_d, x2_q, x2_d, b6_q, b6_d, sq_q, sq_d;
  logic [31:0] b3_q, b3_d, b4_q, b4_d, b7_q, b7_d, p_q, p_d, acc_q, acc_d;
  logic [31:0] mul_a, mul_b, mul_p;
  logic [31:0] num, den, quo, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, t;
  logic        div_busy;
  logic [1:0]  oss;

  assign ac1 = sx16(coef_i.coef_a[15:0]);
  assign ac2 = sx16(coef_i.coef_a[31:16]);
  assign ac3 = sx16(coef_i.coef_a[47:32]);
  assign ac4 = {16'd0, coef_i.coef_a[63:48]};
  assign ac5 = {16'd0, coef_i.coef_b[15:0]};
  assign ac6 = {16'd0, coef_i.coef_b[31:16]};
  assign b1  = sx16(coef_i.coef_b[47:32]);
  assign b2  = sx16(coef_i.coef_b[63:48]);
  assign mc  = sx16(coef_i.coef_c[15:0]);
  assign md  = sx16(coef_i.coef_c[31:16]);
  assign oss = coef_i.oss;

  // One shared 32x32 multiplier, low word only.
  assign mul_p = mul_a * mul_b;

  // Divider operands: temperature uses signed magnitudes, pressure unsigned.
  always_comb begin
    num = '0;
    den = '0;
    if (cmd_i.op == OpT1) begin
      num = mc[31] ? 32'd0 - (mc << 11) : (mc << 11);
      den = x2_q[31] ? 32'd0 - x2_q : x2_q;
    end else if (cmd_i.op == OpP8) begin
      num = b7_q[31] ? b7_q : (b7_q << 1);
      den = b4_q;
    end
  end

  baro_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num),
    .den_i  (den),
    .busy_o (div_busy),
    .quo_o  (quo)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    x1_d = x1_q; x2_d = x2_q; b6_d = b6_q; sq_d = sq_q; b3_d = b3_q;
    b4_d = b4_q; b7_d = b7_q; p_d = p_q; acc_d = acc_q; b5_d = b5_q;
    t = '0;
    case (cmd_i.op)
      OpT0: begin
        mul_a = {13'd0, raw_i} - ac6;
        mul_b = ac5;
        x1_d  = asr32(mul_p, 5'd15);
        x2_d  = asr32(mul_p, 5'd15) + md;
      end
      OpT2: begin
        // Quotient sign follows the operand signs; x2 holds the denominator.
        t    = ((mc[31] != x2_q[31]) ? 32'd0 - quo : quo);
        b5_d = x1_q + t;
      end
      OpT3: acc_d = asr32(b5_q + 32'd8, 5'd4);
      OpP0: b6_d = b5_q - 32'd4000;
      OpP1: begin
        mul_a = b6_q; mul_b = b6_q;
        sq_d  = asr32(mul_p, 5'd12);
      end
      OpP2: begin
        mul_a = b2; mul_b = sq_q;
        x1_d  = asr32(mul_p, 5'd11);
      end
      OpP3: begin
        mul_a = ac2; mul_b = b6_q;
        x2_d  = asr32(mul_p, 5'd11);
      end
      OpP4: begin
        t    = ((ac1 << 2) + x1_q + x2_q) << oss;
        t    = t + 32'd2;
        // Truncating divide by four.
        b3_d = asr32(t[31] ? t + 32'd3 : t, 5'd2);
        mul_a = ac3; mul_b = b6_q;
        x1_d  = asr32(mul_p, 5'd13);
      end
      OpP5: begin
        mul_a = b1; mul_b = sq_q;
        x2_d  = asr32(mul_p, 5'd16);
      end
      OpP6: begin
        mul_a = ac4;
        mul_b = asr32(x1_q + x2_q + 32'd2, 5'd2) + 32'd32768;
        b4_d  = mul_p >> 15;
      end
      OpP7: begin
        mul_a = {13'd0, raw_i} - b3_q;
        mul_b = 32'd50000 >> oss;
        b7_d  = mul_p;
      end
      OpP9: p_d = b7_q[31] ? (quo << 1) : quo;
      OpP10: x1_d = asr32(p_q, 5'd8);
      OpP11: begin
        mul_a = x1_q; mul_b = x1_q;
        x1_d  = mul_p;
      end
      OpP12: begin
        mul_a = x1_q; mul_b = 32'd3038;
        x1_d  = asr32(mul_p, 5'd16);
      end
      OpP13: begin
        mul_a = 32'd0 - 32'd7357; mul_b = p_q;
        x2_d  = asr32(mul_p, 5'd16);
      end
      OpP14: acc_d = p_q + asr32(x1_q + x2_q + 32'd3791, 5'd4);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b5_q <= '0;
    end else begin
      b5_q <= b5_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q <= x1_d; x2_q <= x2_d; b6_q <= b6_d; sq_q <= sq_d; b3_q <= b3_d;
    b4_q <= b4_d; b7_q <= b7_d; p_q <= p_d; acc_q <= acc_d;
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.div_zero = (cmd_i.op == OpT1) ? (x2_q == '0) : (b4_q == '0);
  assign value_o = acc_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op != OpT2) |=> (b5_q == $past(b5_q)))
    else $error("B5 changed outside its update step");

endmodule

// ===== sv/baro_ctrl.sv =====
`timescale 1ns / 1ps
module baro_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 kind_o,
  output logic                 fault_o,
  output logic                 zero_o,
  output baro_pkg::dp_cmd_t    cmd_o,
  input  baro_pkg::dp_sts_t    sts_i
);
  import baro_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StWait = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0] state_q, state_d;
  op_e        op_q, op_d;
  logic       kind_q, kind_d, fault_q, fault_d;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    kind_d  = kind_q;
    fault_d = fault_q;
    cmd_o.op = op_q;
    cmd_o.div_start = 1'b0;
    case (state_q)
      StIdle: begin
        cmd_o.op = OpIdle;
        if (in_valid_i) begin
          kind_d  = mode_i;
          fault_d = 1'b0;
          op_d    = mode_i ? OpP0 : OpT0;
          state_d = StRun;
        end
      end
      StRun: begin
        case (op_q)
          OpT1, OpP8: begin
            if (sts_i.div_zero) begin
              fault_d = 1'b1;
              state_d = StOut;
            end else begin
              cmd_o.div_start = 1'b1;
              op_d    = (op_q == OpT1) ? OpT2 : OpP9;
              state_d = StWait;
            end
          end
          OpT3, OpP14: state_d = StOut;
          default: op_d = op_e'(op_q + 5'd1);
        endcase
      end
      StWait: begin
        cmd_o.op = OpIdle;
        if (!sts_i.div_busy) begin
          state_d = StRun;
        end
      end
      StOut: begin
        cmd_o.op = OpIdle;
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      op_q    <= OpIdle;
      kind_q  <= 1'b0;
      fault_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      kind_q  <= kind_d;
      fault_q <= fault_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign kind_o      = kind_q;
  assign fault_o     = fault_q;
  assign zero_o      = fault_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("took a second item while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(fault_o))
    else $error("result dropped while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> state_q == StWait)
    else $error("divide started outside wait");

endmodule

// ===== sv/barometer_compensation.sv =====
`timescale 1ns / 1ps
// Barometric sensor compensation. mode 0 turns a raw temperature reading into
// 0.1 C and keeps B5; mode 1 turns a raw pressure reading into pascals using
// the kept B5 and the oversampling register. One item is processed at a time:
// each item runs once through the bit-serial divider and uses the shared
// multiplier for each of its multiplies. A zero divisor returns value 0 with
// divide_fault set and skips the divide. Coefficients sit at APB addresses
// 0x0, 0x8 and 0x10, and the oversampling register sits at 0x18.
module barometer_compensation (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  baro_pkg::in_item_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output baro_pkg::out_item_t   out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [baro_pkg::PaddrW-1:0] paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);
  import baro_pkg::*;

  coef_t       coef_q;
  logic [18:0] raw_q;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [31:0] value;
  logic        kind, fault, zero;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && (paddr[2:0] == 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (wr) begin
      case (paddr[4:3])
        RegCoefA: coef_q.coef_a <= pwdata;
        RegCoefB: coef_q.coef_b <= pwdata;
        RegCoefC: coef_q.coef_c <= pwdata[31:0];
        RegOss:   coef_q.oss    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      RegCoefA: prdata = coef_q.coef_a;
      RegCoefB: prdata = coef_q.coef_b;
      RegCoefC: prdata = {32'd0, coef_q.coef_c};
      RegOss:   prdata = {62'd0, coef_q.oss};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      raw_q <= in_data_i.raw_reading;
    end
  end

  baro_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (in_data_i.mode),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind),
    .fault_o    (fault),
    .zero_o     (zero),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  baro_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .coef_i (coef_q),
    .raw_i  (raw_q),
    .value_o(value)
  );

  assign out_data_o.result_kind  = kind;
  assign out_data_o.result_value = zero ? 32'd0 : value;
  assign out_data_o.divide_fault = fault;

endmodule
